// ===== hw/rtl/iprl_pkg.sv =====
`timescale 1ns / 1ps

package iprl_pkg;

	localparam int NUM_ROUTES  = 64;
	localparam int NUM_IFACES  = 16;
	localparam int ADDR_W      = 32;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 6;
	localparam int IFACE_W     = 5;
	localparam int DFLT_W      = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [LEN_W-1:0]      MAX_LEN      = LEN_W'(ADDR_W);
	localparam logic [IFACE_W-1:0]    IFACE_LIMIT  = IFACE_W'(NUM_IFACES);
	localparam logic [DFLT_W-1:0]     DFLT_LIMIT   = DFLT_W'(NUM_ROUTES);
	localparam logic [DFLT_W-1:0]     DFLT_RESET   = DFLT_W'(NUM_ROUTES);
	localparam logic [IFACE_W-1:0]    ENCAP_RESET  = IFACE_W'(NUM_IFACES);

	localparam logic [CFG_IDX_W-1:0]  CFG_DEFAULT_ROUTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  CFG_ENCAP_IFACE   = 1'b1;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_MATCH   = 2'd0,
		KIND_DEFAULT = 2'd1,
		KIND_NONE    = 2'd2,
		KIND_WRITE   = 2'd3
	} kind_t;

	// word moving down the cell chain
	typedef struct packed {
		logic                 vld;
		cmd_t                 cmd;
		logic [IDX_W-1:0]     idx;
		logic                 ent_valid;
		logic [ADDR_W-1:0]    ent_addr;
		logic [LEN_W-1:0]     ent_len;
		logic [IFACE_W-1:0]   ent_iface;
		logic [ADDR_W-1:0]    ent_gw;
		logic [ADDR_W-1:0]    addr;
		logic                 found;
		logic [LEN_W-1:0]     best_len;
		logic [IDX_W-1:0]     best_idx;
		logic                 dflt_ok;
	} word_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		return ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

// ===== hw/rtl/iprl_cell.sv =====
`timescale 1ns / 1ps

module iprl_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [iprl_pkg::IDX_W-1:0]    cell_idx,
	input  logic [iprl_pkg::DFLT_W-1:0]   dflt_route,
	input  logic [iprl_pkg::IFACE_W-1:0]  encap_iface,
	input  iprl_pkg::word_t               word_in,
	output iprl_pkg::word_t               word_out
);

	logic                          valid_q;
	logic [iprl_pkg::ADDR_W-1:0]   prefix_q;
	logic [iprl_pkg::LEN_W-1:0]    len_q;
	logic [iprl_pkg::IFACE_W-1:0]  iface_q;
	logic [iprl_pkg::ADDR_W-1:0]   gw_q;

	logic                          wr_hit;
	logic                          len_ok;
	logic                          skip;
	logic                          hit;
	logic                          better;
	iprl_pkg::word_t               word_nxt;
	iprl_pkg::word_t               word_q;
	logic                          word_vld_q;

	assign wr_hit = word_in.vld && (word_in.cmd == iprl_pkg::CMD_WRITE) &&
		(word_in.idx == cell_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv && wr_hit) begin
			valid_q <= word_in.ent_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr_hit) begin
			prefix_q <= word_in.ent_addr;
			len_q    <= word_in.ent_len;
			iface_q  <= word_in.ent_iface;
			gw_q     <= word_in.ent_gw;
		end
	end

	assign len_ok = (len_q != '0) && (len_q <= iprl_pkg::MAX_LEN);
	// tunnel route that points back at the destination itself
	assign skip   = (encap_iface < iprl_pkg::IFACE_LIMIT) && (iface_q == encap_iface) &&
		(gw_q == word_in.addr);
	assign hit    = valid_q && len_ok && !skip &&
		(prefix_q == (word_in.addr & iprl_pkg::prefix_mask(len_q)));
	// strict compare: on equal length the earlier, lower index keeps the win
	assign better = hit && (!word_in.found || (len_q > word_in.best_len));

	always_comb begin
		word_nxt = word_in;
		if (word_in.cmd == iprl_pkg::CMD_LOOKUP) begin
			if (better) begin
				word_nxt.found    = 1'b1;
				word_nxt.best_len = len_q;
				word_nxt.best_idx = cell_idx;
			end
			if ({1'b0, cell_idx} == dflt_route) begin
				word_nxt.dflt_ok = iface_q < iprl_pkg::IFACE_LIMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= 1'b0;
		end else if (adv) begin
			word_vld_q <= word_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_nxt;
		end
	end

	always_comb begin
		word_out     = word_q;
		word_out.vld = word_vld_q;
	end

endmodule

// ===== hw/rtl/ip_route_longest_prefix_lookup_top.sv =====
`timescale 1ns / 1ps
// channel  valid      stall      payload
// req      req_valid  req_stall  cmd, entry_*, lookup_addr
// rsp      rsp_valid  rsp_stall  route_index, result_kind
// cfg      cfg_we     -          cfg_index, cfg_wdata
//
// One cell per route entry; a word walks the chain one cell per cycle while
// rsp is not stalled, via the NUM_ROUTES cells (the chain length sets the latency)
// and then the rsp register; a new word is accepted every cycle req_stall is low.
// Reset clears valid marks, sets the config out of range; entries need no sweep.
// A held result on rsp freezes the whole chain and raises req_stall.

module ip_route_longest_prefix_lookup_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [iprl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [iprl_pkg::CFG_DATA_W-1:0]      cfg_wdata,

	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 cmd,
	input  logic [iprl_pkg::IDX_W-1:0]           entry_index,
	input  logic                                 entry_valid,
	input  logic [iprl_pkg::ADDR_W-1:0]          entry_prefix_addr,
	input  logic [iprl_pkg::LEN_W-1:0]           entry_prefix_len,
	input  logic [iprl_pkg::IFACE_W-1:0]         entry_iface,
	input  logic [iprl_pkg::ADDR_W-1:0]          entry_gateway,
	input  logic [iprl_pkg::ADDR_W-1:0]          lookup_addr,

	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [iprl_pkg::IDX_W-1:0]           route_index,
	output logic [1:0]                           result_kind
);

	logic [iprl_pkg::DFLT_W-1:0]   default_route_q;
	logic [iprl_pkg::IFACE_W-1:0]  encap_iface_q;
	logic                          adv;
	iprl_pkg::word_t               head;
	iprl_pkg::word_t               chain [0:iprl_pkg::NUM_ROUTES];
	iprl_pkg::word_t               last;

	logic                          rsp_valid_q;
	logic [iprl_pkg::IDX_W-1:0]    route_index_q;
	iprl_pkg::kind_t               result_kind_q;
	logic [iprl_pkg::IDX_W-1:0]    idx_nxt;
	iprl_pkg::kind_t               kind_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_route_q <= iprl_pkg::DFLT_RESET;
			encap_iface_q   <= iprl_pkg::ENCAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				iprl_pkg::CFG_DEFAULT_ROUTE: default_route_q <= cfg_wdata;
				iprl_pkg::CFG_ENCAP_IFACE:   encap_iface_q   <= cfg_wdata[iprl_pkg::IFACE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;

	always_comb begin
		head           = '0;
		head.vld       = req_valid;
		head.cmd       = iprl_pkg::cmd_t'(cmd);
		head.idx       = entry_index;
		head.ent_valid = entry_valid;
		head.ent_addr  = entry_prefix_addr;
		head.ent_len   = entry_prefix_len;
		head.ent_iface = entry_iface;
		head.ent_gw    = entry_gateway;
		head.addr      = lookup_addr;
	end

	assign chain[0] = head;

	for (genvar g = 0; g < iprl_pkg::NUM_ROUTES; g++) begin : g_cell
		iprl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.cell_idx    (iprl_pkg::IDX_W'(g)),
			.dflt_route  (default_route_q),
			.encap_iface (encap_iface_q),
			.word_in     (chain[g]),
			.word_out    (chain[g+1])
		);
	end

	assign last = chain[iprl_pkg::NUM_ROUTES];

	always_comb begin
		idx_nxt  = '0;
		kind_nxt = iprl_pkg::KIND_NONE;
		if (last.cmd == iprl_pkg::CMD_WRITE) begin
			kind_nxt = iprl_pkg::KIND_WRITE;
		end else if (last.found) begin
			idx_nxt  = last.best_idx;
			kind_nxt = iprl_pkg::KIND_MATCH;
		end else if ((default_route_q < iprl_pkg::DFLT_LIMIT) && last.dflt_ok) begin
			idx_nxt  = default_route_q[iprl_pkg::IDX_W-1:0];
			kind_nxt = iprl_pkg::KIND_DEFAULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			route_index_q <= idx_nxt;
			result_kind_q <= kind_nxt;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign route_index = route_index_q;
	assign result_kind = result_kind_q;

endmodule
